// File: src/assert_macros.svh
// assertion helpers, sampled on clk with arst_n as the disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("assertion failed");

`endif

// File: src/tcc_pkg.sv
`timescale 1ns / 1ps
package tcc_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [31:0] TICKET_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_RESERVE  = 3'd0,
		OP_PUBLISH  = 3'd1,
		OP_POP      = 3'd2,
		OP_RELEASE  = 3'd3,
		OP_PUSH_RET = 3'd4,
		OP_POP_RET  = 3'd5,
		OP_CANCEL   = 3'd6,
		OP_WAKE     = 3'd7
	} op_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic exec;
	} cmd_t;
endpackage

// File: src/tcc_req_if.sv
`timescale 1ns / 1ps
interface tcc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] corr_id;
	logic [31:0] ticket_in;
	logic [31:0] done_return_id;
	logic [31:0] done_entry_id;
	logic [31:0] done_payload;
	logic [31:0] room_id;
	logic [31:0] player_id;

	modport source (output valid, opcode, corr_id, ticket_in, done_return_id,
		done_entry_id, done_payload, room_id, player_id, input ready);
	modport sink (input valid, opcode, corr_id, ticket_in, done_return_id,
		done_entry_id, done_payload, room_id, player_id, output ready);
endinterface

// File: src/tcc_rsp_if.sv
`timescale 1ns / 1ps
interface tcc_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [31:0] ticket_out;
	logic [31:0] out_return_id;
	logic [31:0] out_entry_id;
	logic [31:0] out_payload;
	logic [31:0] out_room;
	logic [31:0] out_player;
	logic        wake;
	logic        drained;

	modport source (output valid, accepted, ticket_out, out_return_id, out_entry_id,
		out_payload, out_room, out_player, wake, drained, input ready);
	modport sink (input valid, accepted, ticket_out, out_return_id, out_entry_id,
		out_payload, out_room, out_player, wake, drained, output ready);
endinterface

// File: src/tcc_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output tcc_pkg::cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_EXEC = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_LOOK;
			S_LOOK: state_d = S_EXEC;
			S_EXEC: state_d = S_OUT;
			S_OUT:  if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.lookup = (state_q == S_LOOK);
	assign cmd.exec   = (state_q == S_EXEC);

	`ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
	`ASSERT_NEXT(a_accept_looks, cmd.load, cmd.lookup && !in_ready)
	`ASSERT_NEXT(a_exec_shows, cmd.exec, out_valid)
endmodule

// File: src/tcc_dp.sv
`timescale 1ns / 1ps
module tcc_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  tcc_pkg::cmd_t  cmd,
	tcc_req_if.sink        req,
	tcc_rsp_if.source      rsp
);
	localparam int CAP = tcc_pkg::CAPACITY;
	localparam int IW  = tcc_pkg::IDX_W;
	localparam int CW  = tcc_pkg::CNT_W;

	typedef struct packed {
		logic [IW-1:0] idx;
		logic [31:0]   ret;
		logic [31:0]   ent;
		logic [31:0]   pay;
	} done_ent_t;

	typedef struct packed {
		logic [31:0] room;
		logic [31:0] player;
	} ret_ent_t;

	// latched request
	logic [2:0]  op_q;
	logic [31:0] corr_q, tin_q, dret_q, dent_q, dpay_q, room_q, player_q;

	// table and ring state
	logic [31:0]    next_ticket_q;
	logic           cancelled_q;
	logic [CAP-1:0] rv_q, rqueued_q, rpend_q;
	logic [31:0]    rticket_q [CAP];
	logic [31:0]    rcorr_q [CAP];
	done_ent_t      done_mem [CAP];
	ret_ent_t       ret_mem [CAP];
	logic [IW-1:0]  dhead_q, dtail_q, rhead_q, rtail_q;
	logic [CW-1:0]  dcount_q, rcount_q;

	// lookup stage
	logic          hit_s1, free_s1;
	logic [IW-1:0] hidx_s1, fidx_s1;
	done_ent_t     dring_s1;
	ret_ent_t      rring_s1;

	// result beat
	logic        acc_q, wake_q, drained_q;
	logic [31:0] tout_q, oret_q, oent_q, opay_q, oroom_q, oplayer_q;

	function automatic logic [IW-1:0] adv(input logic [IW-1:0] p);
		adv = (p == IW'(CAP - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.opcode;
			corr_q   <= req.corr_id;
			tin_q    <= req.ticket_in;
			dret_q   <= req.done_return_id;
			dent_q   <= req.done_entry_id;
			dpay_q   <= req.done_payload;
			room_q   <= req.room_id;
			player_q <= req.player_id;
		end
	end

	// ticket match over the table and lowest free entry
	logic          hit_c, free_c;
	logic [IW-1:0] hidx_c, fidx_c;

	always_comb begin
		hit_c  = 1'b0;
		free_c = 1'b0;
		hidx_c = '0;
		fidx_c = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (rv_q[i] && rticket_q[i] == tin_q && tin_q != 32'd0) begin
				hit_c  = 1'b1;
				hidx_c = IW'(i);
			end
			if (!rv_q[i]) begin
				free_c = 1'b1;
				fidx_c = IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s1   <= hit_c;
			hidx_s1  <= hidx_c;
			free_s1  <= free_c;
			fidx_s1  <= fidx_c;
			dring_s1 <= done_mem[dhead_q];
			rring_s1 <= ret_mem[rhead_q];
		end
	end

	// execute
	logic [CAP-1:0] rv_n, rq_n, rp_n;
	logic [IW-1:0]  dhead_n, dtail_n, rhead_n, rtail_n;
	logic [CW-1:0]  dcount_n, rcount_n;
	logic [31:0]    next_ticket_n, expect_id;
	logic           canc_n, acc_n, wake_n, wr_resv, wr_done, wr_ret;
	logic [31:0]    tout_n, oret_n, oent_n, opay_n, oroom_n, oplayer_n;

	always_comb begin
		rv_n = rv_q;
		rq_n = rqueued_q;
		rp_n = rpend_q;
		dhead_n = dhead_q;
		dtail_n = dtail_q;
		rhead_n = rhead_q;
		rtail_n = rtail_q;
		dcount_n = dcount_q;
		rcount_n = rcount_q;
		next_ticket_n = next_ticket_q;
		canc_n = cancelled_q;
		acc_n = 1'b0;
		wake_n = 1'b0;
		wr_resv = 1'b0;
		wr_done = 1'b0;
		wr_ret = 1'b0;
		tout_n = '0;
		oret_n = '0;
		oent_n = '0;
		opay_n = '0;
		oroom_n = '0;
		oplayer_n = '0;
		expect_id = (dret_q != 32'd0) ? dret_q : dent_q;
		unique case (tcc_pkg::op_t'(op_q))
			tcc_pkg::OP_RESERVE: begin
				if (!cancelled_q && corr_q != 32'd0 && next_ticket_q != tcc_pkg::TICKET_MAX
						&& free_s1) begin
					wr_resv = 1'b1;
					rv_n[fidx_s1] = 1'b1;
					rq_n[fidx_s1] = 1'b0;
					rp_n[fidx_s1] = 1'b0;
					acc_n = 1'b1;
					tout_n = next_ticket_q;
					next_ticket_n = next_ticket_q + 32'd1;
				end
			end
			tcc_pkg::OP_PUBLISH: begin
				if (!cancelled_q && hit_s1 && rcorr_q[hidx_s1] == expect_id
						&& !rqueued_q[hidx_s1] && dcount_q < CW'(CAP)) begin
					wr_done = 1'b1;
					dtail_n = adv(dtail_q);
					dcount_n = dcount_q + 1'b1;
					rq_n[hidx_s1] = 1'b1;
					acc_n = 1'b1;
					wake_n = 1'b1;
				end
			end
			tcc_pkg::OP_POP: begin
				if (dcount_q != '0) begin
					dhead_n = adv(dhead_q);
					dcount_n = dcount_q - 1'b1;
					// ring keeps the table slot, tickets are never reused
					if (rv_q[dring_s1.idx] && rqueued_q[dring_s1.idx]) begin
						rq_n[dring_s1.idx] = 1'b0;
						if (rpend_q[dring_s1.idx]) begin
							rv_n[dring_s1.idx] = 1'b0;
							rp_n[dring_s1.idx] = 1'b0;
						end
					end
					acc_n = 1'b1;
					oret_n = dring_s1.ret;
					oent_n = dring_s1.ent;
					opay_n = dring_s1.pay;
				end
			end
			tcc_pkg::OP_RELEASE: begin
				if (hit_s1) begin
					if (rqueued_q[hidx_s1]) rp_n[hidx_s1] = 1'b1;
					else rv_n[hidx_s1] = 1'b0;
					acc_n = 1'b1;
				end
			end
			tcc_pkg::OP_PUSH_RET: begin
				if (!cancelled_q && room_q != 32'd0 && player_q != 32'd0
						&& rcount_q < CW'(CAP)) begin
					wr_ret = 1'b1;
					rtail_n = adv(rtail_q);
					rcount_n = rcount_q + 1'b1;
					acc_n = 1'b1;
					wake_n = 1'b1;
				end
			end
			tcc_pkg::OP_POP_RET: begin
				if (rcount_q != '0) begin
					rhead_n = adv(rhead_q);
					rcount_n = rcount_q - 1'b1;
					acc_n = 1'b1;
					oroom_n = rring_s1.room;
					oplayer_n = rring_s1.player;
				end
			end
			tcc_pkg::OP_CANCEL: begin
				rv_n = '0;
				rq_n = '0;
				rp_n = '0;
				dhead_n = '0;
				dtail_n = '0;
				rhead_n = '0;
				rtail_n = '0;
				dcount_n = '0;
				rcount_n = '0;
				canc_n = 1'b1;
				acc_n = 1'b1;
				wake_n = 1'b1;
			end
			tcc_pkg::OP_WAKE: begin
				acc_n = (dcount_q != '0) || (rcount_q != '0);
				wake_n = acc_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ticket_q <= 32'd1;
			cancelled_q <= 1'b0;
			rv_q <= '0;
			rqueued_q <= '0;
			rpend_q <= '0;
			dhead_q <= '0;
			dtail_q <= '0;
			rhead_q <= '0;
			rtail_q <= '0;
			dcount_q <= '0;
			rcount_q <= '0;
		end else if (cmd.exec) begin
			next_ticket_q <= next_ticket_n;
			cancelled_q <= canc_n;
			rv_q <= rv_n;
			rqueued_q <= rq_n;
			rpend_q <= rp_n;
			dhead_q <= dhead_n;
			dtail_q <= dtail_n;
			rhead_q <= rhead_n;
			rtail_q <= rtail_n;
			dcount_q <= dcount_n;
			rcount_q <= rcount_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_resv) begin
			rticket_q[fidx_s1] <= next_ticket_q;
			rcorr_q[fidx_s1] <= corr_q;
		end
		if (cmd.exec && wr_done)
			done_mem[dtail_q] <= '{idx: hidx_s1, ret: dret_q, ent: dent_q, pay: dpay_q};
		if (cmd.exec && wr_ret)
			ret_mem[rtail_q] <= '{room: room_q, player: player_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			acc_q <= acc_n;
			wake_q <= wake_n;
			drained_q <= (dcount_n == '0) && (rcount_n == '0) && (rv_n == '0);
			tout_q <= tout_n;
			oret_q <= oret_n;
			oent_q <= oent_n;
			opay_q <= opay_n;
			oroom_q <= oroom_n;
			oplayer_q <= oplayer_n;
		end
	end

	assign rsp.accepted      = acc_q;
	assign rsp.ticket_out    = tout_q;
	assign rsp.out_return_id = oret_q;
	assign rsp.out_entry_id  = oent_q;
	assign rsp.out_payload   = opay_q;
	assign rsp.out_room      = oroom_q;
	assign rsp.out_player    = oplayer_q;
	assign rsp.wake          = wake_q;
	assign rsp.drained       = drained_q;
endmodule

// File: src/ticketed_completion_channel.sv
`timescale 1ns / 1ps
// order: an accepted request beat passes the table lookup, execute and result
// stages of the sequencer; no new request is accepted until the result beat
// is taken, and the result stage holds while the result stalls
// reset: arst_n clears the table valid bits, ring pointers and counts,
// the cancel flag, and sets the next ticket to one
module ticketed_completion_channel (
	input  logic      clk,
	input  logic      arst_n,
	tcc_req_if.sink   req,
	tcc_rsp_if.source rsp
);
	tcc_pkg::cmd_t cmd;

	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	tcc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);
endmodule
